/* hdl/hierarchical_timer_wheel_macros.svh */
// Assertion macros of the timer wheel RTL
`ifndef HIERARCHICAL_TIMER_WHEEL_MACROS_SVH
`define HIERARCHICAL_TIMER_WHEEL_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define HTW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define HTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/htw_pkg.sv */
// Types, constants and helpers of the hierarchical timer wheel
`default_nettype none
package htw_pkg;

  localparam int TIMER_COUNT = 64;
  localparam int ID_W        = 6;
  localparam int WHEEL_SLOTS = 64;
  localparam int SLOT_W      = 6;
  localparam int MAX_LAYERS  = 4;
  localparam int LAYER_W     = 2;
  localparam int LCNT_W      = 3;
  localparam int TIME_W      = 40;
  localparam int DELAY_W     = 32;
  localparam int ROUNDS_W    = 14;
  localparam int KIND_W      = 3;
  localparam int OP_W        = 2;

  localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = 14'h3FFF;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

  localparam logic [KIND_W-1:0] RK_ADDED       = 3'd0;
  localparam logic [KIND_W-1:0] RK_ADD_REJ     = 3'd1;
  localparam logic [KIND_W-1:0] RK_CANCELLED   = 3'd2;
  localparam logic [KIND_W-1:0] RK_CANCEL_UNK  = 3'd3;
  localparam logic [KIND_W-1:0] RK_EXPIRED     = 3'd4;
  localparam logic [KIND_W-1:0] RK_ACTIVE      = 3'd5;
  localparam logic [KIND_W-1:0] RK_INACTIVE    = 3'd6;

  typedef struct packed {
    logic [TIME_W-1:0]   expire;
    logic [DELAY_W-1:0]  interval;
    logic [LAYER_W-1:0]  layer;
    logic [SLOT_W-1:0]   slot;
    logic [ROUNDS_W-1:0] rounds;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   timer;
    logic              last;
  } result_t;

  function automatic logic [SLOT_W-1:0] cursor_of(input logic [TIME_W-1:0] t,
                                                  input logic [LAYER_W-1:0] l);
    logic [TIME_W-1:0] sh;
    sh = t;
    for (int i = 0; i < MAX_LAYERS; i++) begin
      if (l == LAYER_W'(i)) begin
        sh = t >> (SLOT_W * i);
      end
    end
    return sh[SLOT_W-1:0];
  endfunction

  function automatic logic wrapped_at(input logic [TIME_W-1:0] t,
                                      input logic [LAYER_W-1:0] l);
    logic [TIME_W-1:0] msk;
    msk = '0;
    for (int i = 0; i < MAX_LAYERS; i++) begin
      if (l == LAYER_W'(i)) begin
        msk = (TIME_W'(1) << (SLOT_W * i)) - TIME_W'(1);
      end
    end
    return (t & msk) == '0;
  endfunction

endpackage
`default_nettype wire

/* hdl/htw_place.sv */
// Placement unit: layer, slot and revolution count for one timer, three stages
`default_nettype none
module htw_place import htw_pkg::*; (
  input  wire logic                clk,
  input  wire logic [TIME_W-1:0]   now,
  input  wire logic [TIME_W-1:0]   expire,
  input  wire logic [LCNT_W-1:0]   layers,
  output logic      [LAYER_W-1:0]  layer,
  output logic      [SLOT_W-1:0]   slot,
  output logic      [ROUNDS_W-1:0] rounds
);

  logic [TIME_W-1:0]  diff;
  logic [TIME_W-1:0]  gap;
  logic [LAYER_W-1:0] lay_c;
  logic [TIME_W-1:0]  gap1;
  logic [LAYER_W-1:0] lay1;
  logic [TIME_W-1:0]  low;
  logic [TIME_W:0]    sum;
  logic [TIME_W:0]    q_c;
  logic [TIME_W:0]    q2;
  logic [LAYER_W-1:0] lay2;
  logic [TIME_W:0]    qm1;
  logic [TIME_W:0]    rnd;

  always_comb begin
    diff  = expire - now;
    gap   = diff[TIME_W-1] ? '0 : diff;
    lay_c = '0;
    for (int i = 1; i < MAX_LAYERS; i++) begin
      if ((LCNT_W'(i) < layers) && ((gap >> (SLOT_W * i)) != '0)) begin
        lay_c = LAYER_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    gap1 <= gap;
    lay1 <= lay_c;
  end

  always_comb begin
    low = '0;
    for (int i = 0; i < MAX_LAYERS; i++) begin
      if (lay1 == LAYER_W'(i)) begin
        low = now & ((TIME_W'(1) << (SLOT_W * i)) - TIME_W'(1));
      end
    end
    sum = {1'b0, low} + {1'b0, gap1};
    q_c = sum;
    for (int i = 0; i < MAX_LAYERS; i++) begin
      if (lay1 == LAYER_W'(i)) begin
        q_c = sum >> (SLOT_W * i);
      end
    end
  end

  always_ff @(posedge clk) begin
    q2   <= q_c;
    lay2 <= lay1;
  end

  always_comb begin
    qm1   = q2 - (TIME_W+1)'(1);
    rnd   = qm1 >> SLOT_W;
    layer = lay2;
    slot  = cursor_of(now, lay2) + q2[SLOT_W-1:0];
    if (q2 == '0) begin
      rounds = '0;
    end else if (rnd > (TIME_W+1)'(ROUNDS_MAX)) begin
      rounds = ROUNDS_MAX;
    end else begin
      rounds = rnd[ROUNDS_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* hdl/htw_ctrl.sv */
// Sequencer, timer pool memory and busy/due flags of the timer wheel
`default_nettype none
`include "hierarchical_timer_wheel_macros.svh"
module htw_ctrl import htw_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [OP_W-1:0]    opcode,
  input  wire logic [ID_W-1:0]    timer_id,
  input  wire logic [DELAY_W-1:0] delay_ticks,
  input  wire logic               repeat_req,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LCNT_W-1:0]  cfg_data,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output result_t                 res
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_EVAL   = 4'd2;
  localparam logic [3:0] S_P1     = 4'd3;
  localparam logic [3:0] S_P2     = 4'd4;
  localparam logic [3:0] S_P3     = 4'd5;
  localparam logic [3:0] S_WRITE  = 4'd6;
  localparam logic [3:0] S_DUEOUT = 4'd7;
  localparam logic [3:0] S_ADV    = 4'd8;
  localparam logic [3:0] S_LVL    = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  localparam logic [2:0] PH_ADD   = 3'd0;
  localparam logic [2:0] PH_DUE   = 3'd1;
  localparam logic [2:0] PH_CASC  = 3'd2;
  localparam logic [2:0] PH_REARM = 3'd3;
  localparam logic [2:0] PH_CFG   = 3'd4;

  localparam logic [ID_W-1:0] LAST = ID_W'(TIMER_COUNT - 1);

  logic [3:0]             state;
  logic [3:0]             ret;
  logic [2:0]             phase;
  logic [ID_W-1:0]        idx;
  logic [LAYER_W-1:0]     lvl;
  logic [TIME_W-1:0]      now;
  logic [LCNT_W-1:0]      layers;
  logic [TIMER_COUNT-1:0] busy;
  logic [TIMER_COUNT-1:0] due;
  logic [DELAY_W-1:0]     dly;
  logic                   rep;
  entry_t                 ent;
  entry_t                 rd;
  entry_t                 rd_dec;
  entry_t                 rd_rearm;
  result_t                pend;
  logic [ID_W-1:0]        hold_t;
  logic                   hold_v;
  entry_t                 mem [TIMER_COUNT];
  logic [LAYER_W-1:0]     pl_layer;
  logic [SLOT_W-1:0]      pl_slot;
  logic [ROUNDS_W-1:0]    pl_rounds;

  function automatic logic [LCNT_W-1:0] clamp_layers(input logic [LCNT_W-1:0] v);
    logic [LCNT_W-1:0] r;
    r = v;
    if (r < LCNT_W'(2)) r = LCNT_W'(2);
    if (r > LCNT_W'(MAX_LAYERS)) r = LCNT_W'(MAX_LAYERS);
    return r;
  endfunction

  htw_place u_place (
    .clk    (clk),
    .now    (now),
    .expire (ent.expire),
    .layers (layers),
    .layer  (pl_layer),
    .slot   (pl_slot),
    .rounds (pl_rounds)
  );

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign res_valid = (state == S_EMIT);
  assign res       = pend;

  always_comb begin
    rd_dec          = rd;
    rd_dec.rounds   = rd.rounds - ROUNDS_W'(1);
    rd_rearm        = rd;
    rd_rearm.expire = now + TIME_W'(rd.interval);
  end

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      mem[idx] <= ent;
    end
    rd <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      now    <= '0;
      layers <= LCNT_W'(MAX_LAYERS);
      busy   <= '0;
      due    <= '0;
      hold_v <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            layers <= clamp_layers(cfg_data);
            phase  <= PH_CFG;
            idx    <= '0;
            state  <= S_SCAN;
          end else if (in_valid) begin
            dly <= delay_ticks;
            rep <= repeat_req;
            unique case (opcode)
              OP_TICK: begin
                phase <= PH_DUE;
                idx   <= '0;
                due   <= '0;
                state <= S_SCAN;
              end
              OP_ADD: begin
                if (delay_ticks == '0) begin
                  pend  <= {RK_ADD_REJ, ID_W'(0), 1'b1};
                  ret   <= S_IDLE;
                  state <= S_EMIT;
                end else begin
                  phase <= PH_ADD;
                  idx   <= '0;
                  state <= S_SCAN;
                end
              end
              OP_CANCEL: begin
                if (busy[timer_id]) begin
                  busy[timer_id] <= 1'b0;
                  pend <= {RK_CANCELLED, timer_id, 1'b1};
                end else begin
                  pend <= {RK_CANCEL_UNK, timer_id, 1'b1};
                end
                ret   <= S_IDLE;
                state <= S_EMIT;
              end
              OP_QUERY: begin
                pend  <= {(busy[timer_id] ? RK_ACTIVE : RK_INACTIVE), timer_id, 1'b1};
                ret   <= S_IDLE;
                state <= S_EMIT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          unique case (phase)
            PH_ADD: begin
              if (!busy[idx]) begin
                busy[idx] <= 1'b1;
                ent       <= {now + TIME_W'(dly), (rep ? dly : DELAY_W'(0)),
                              ent.layer, ent.slot, ent.rounds};
                state     <= S_P1;
              end else if (idx == LAST) begin
                pend  <= {RK_ADD_REJ, ID_W'(0), 1'b1};
                ret   <= S_IDLE;
                state <= S_EMIT;
              end else begin
                idx <= idx + ID_W'(1);
              end
            end
            PH_DUE, PH_CFG: state <= busy[idx] ? S_EVAL : S_ADV;
            PH_CASC:        state <= (busy[idx] && !due[idx]) ? S_EVAL : S_ADV;
            PH_REARM: begin
              if (!due[idx]) state <= S_ADV;
              else if (busy[idx]) state <= S_EVAL;
              else state <= S_DUEOUT;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_EVAL: begin
          unique case (phase)
            PH_DUE: begin
              if ((rd.layer == '0) && (rd.slot == cursor_of(now, '0))) begin
                if (rd.rounds != '0) begin
                  ent   <= rd_dec;
                  state <= S_WRITE;
                end else begin
                  due[idx] <= 1'b1;
                  if (rd.interval == '0) busy[idx] <= 1'b0;
                  state <= S_ADV;
                end
              end else begin
                state <= S_ADV;
              end
            end
            PH_CASC: begin
              if ((rd.layer == lvl) && (rd.slot == cursor_of(now, lvl))) begin
                if (rd.rounds != '0) begin
                  ent   <= rd_dec;
                  state <= S_WRITE;
                end else begin
                  ent   <= rd;
                  state <= S_P1;
                end
              end else begin
                state <= S_ADV;
              end
            end
            PH_REARM: begin
              ent   <= rd_rearm;
              state <= S_P1;
            end
            PH_CFG: begin
              ent   <= rd;
              state <= S_P1;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_P1: state <= S_P2;
        S_P2: state <= S_P3;
        S_P3: begin
          ent   <= {ent.expire, ent.interval, pl_layer, pl_slot, pl_rounds};
          state <= S_WRITE;
        end
        S_WRITE: begin
          unique case (phase)
            PH_ADD: begin
              pend  <= {RK_ADDED, idx, 1'b1};
              ret   <= S_IDLE;
              state <= S_EMIT;
            end
            PH_REARM: state <= S_DUEOUT;
            default:  state <= S_ADV;
          endcase
        end
        S_DUEOUT: begin
          hold_t <= idx;
          hold_v <= 1'b1;
          if (hold_v) begin
            pend  <= {RK_EXPIRED, hold_t, 1'b0};
            ret   <= S_ADV;
            state <= S_EMIT;
          end else begin
            state <= S_ADV;
          end
        end
        S_ADV: begin
          if (idx != LAST) begin
            idx   <= idx + ID_W'(1);
            state <= S_SCAN;
          end else begin
            unique case (phase)
              PH_DUE: begin
                now   <= now + TIME_W'(1);
                lvl   <= LAYER_W'(layers - LCNT_W'(1));
                state <= S_LVL;
              end
              PH_CASC: begin
                lvl   <= lvl - LAYER_W'(1);
                state <= S_LVL;
              end
              PH_REARM: begin
                hold_v <= 1'b0;
                if (hold_v) begin
                  pend  <= {RK_EXPIRED, hold_t, 1'b1};
                  ret   <= S_IDLE;
                  state <= S_EMIT;
                end else begin
                  state <= S_IDLE;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LVL: begin
          if (lvl == '0) begin
            phase  <= PH_REARM;
            idx    <= '0;
            hold_v <= 1'b0;
            state  <= S_SCAN;
          end else if (wrapped_at(now, lvl)) begin
            phase <= PH_CASC;
            idx   <= '0;
            state <= S_SCAN;
          end else begin
            lvl <= lvl - LAYER_W'(1);
          end
        end
        S_EMIT: begin
          if (res_ready) state <= ret;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `HTW_ASSERT_IMPL(a_add_marks_busy, (state == S_WRITE) && (phase == PH_ADD), busy[idx], "added entry not busy")
  `HTW_ASSERT_IMPL(a_layer_in_use, state == S_P3, LCNT_W'(pl_layer) < layers, "placed above active layers")
  `HTW_ASSERT_IMPL(a_last_ends_item, (state == S_EMIT) && pend.last, ret == S_IDLE, "final word does not end item")
  `HTW_ASSERT_NEXT(a_tick_advances, (state == S_ADV) && (phase == PH_DUE) && (idx == LAST), now == $past(now) + TIME_W'(1), "time did not advance")

endmodule
`default_nettype wire

/* hdl/hierarchical_timer_wheel.sv */
// Top level of the hierarchical timer wheel: ports, word packing, output register
//
// channel  direction  handshake                     payload
// s_axis   in         s_axis_tvalid/s_axis_tready   tdata, tuser
// m_axis   out        m_axis_tvalid/m_axis_tready   tdata, tuser, tlast
// cfg      in         cfg_valid/cfg_ready           cfg_data (layers_in_use)
//
// Query, cancel and a zero-delay add go straight to the result; any other add scans the pool
// past busy entries to the first free one and places it.
// Tick walks the 64-entry pool in up to 5 passes (due, cascades, re-arm); each busy entry
// visited is read and evaluated, and each entry placed goes through the placement unit's
// 3 stages and the write.
// Config write re-places every busy entry in one pass.
// Reset clears the busy flags; the pool memory is not cleared.
// A stalled m_axis holds the sequencer at its next word; s_axis is ready only when idle.
`default_nettype none
module hierarchical_timer_wheel import htw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // timer_id[5:0], delay_ticks[37:6], repeat_req[38]
  input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // result_timer[5:0]
  output logic [2:0]       m_axis_tuser,  // result_kind[2:0]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data
);

  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_word;

  htw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .opcode      (s_axis_tuser),
    .timer_id    (s_axis_tdata[5:0]),
    .delay_ticks (s_axis_tdata[37:6]),
    .repeat_req  (s_axis_tdata[38]),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_word <= res;
    end
  end

  assign m_axis_tdata = {2'b00, out_word.timer};
  assign m_axis_tuser = out_word.kind;
  assign m_axis_tlast = out_word.last;

endmodule
`default_nettype wire
